@@ rtl/lcbf_pkg.sv @@
// Package for the lidar cluster box filter.
// Payload, configuration types and register indexes; no dependencies.
package lcbf_pkg;

    typedef struct packed {
        logic signed [15:0] pt_x;
        logic signed [15:0] pt_y;
        logic signed [15:0] pt_z;
        logic               cluster_end;
    } pt_t;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic signed [15:0] box_min_x;
        logic signed [15:0] box_max_x;
        logic signed [15:0] box_min_y;
        logic signed [15:0] box_max_y;
        logic signed [15:0] box_min_z;
        logic signed [15:0] box_max_z;
        logic        [2:0]  verdict;
    } box_t;

    typedef struct packed {
        logic        [12:0] pole_point_limit;
        logic        [29:0] pole_radius_sq;
        logic        [31:0] max_small_volume;
        logic signed [15:0] high_base_margin;
        logic signed [15:0] under_z_margin;
        logic signed [15:0] vehicle_height;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_POLE_POINT_LIMIT = 3'd0,
        REG_POLE_RADIUS      = 3'd1,
        REG_MAX_SMALL_VOLUME = 3'd2,
        REG_HIGH_BASE_MARGIN = 3'd3,
        REG_UNDER_Z_MARGIN   = 3'd4,
        REG_VEHICLE_HEIGHT   = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        V_KEPT       = 3'd0,
        V_POLE       = 3'd1,
        V_SMALL      = 3'd2,
        V_HIGH       = 3'd3,
        V_FLAT       = 3'd4,
        V_LOW        = 3'd5,
        V_LONG_FLAT  = 3'd6,
        V_CENTRE_HI  = 3'd7
    } verdict_t;

    localparam logic [31:0] LONG_DIAG_SQ = 32'd1638400;
    localparam logic [15:0] FLAT_DZ_MAX  = 16'd38;
    localparam logic [15:0] LONG_DZ_LIM  = 16'd128;
    localparam logic signed [16:0] LOW_MARGIN = 17'sd25;

endpackage

@@ rtl/lcbf_ifs.sv @@
// Valid/ready channel interfaces for points and box records.
// Depends on lcbf_pkg.
interface lcbf_pt_if
    import lcbf_pkg::*;
();
    logic valid;
    logic ready;
    pt_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lcbf_box_if
    import lcbf_pkg::*;
();
    logic valid;
    logic ready;
    box_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lcbf_queue.sv @@
// Small record queue between the point front end and the back end.
// No package dependency.
module lcbf_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [W-1:0]               push_data,
    input  logic                       pop,
    output logic [W-1:0]               head,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] used
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign head  = mem[rp_reg];
    assign empty = (cnt_reg == '0);
    assign used  = cnt_reg;
endmodule

@@ rtl/lcbf_front.sv @@
// Point front end: box, sums, count and pole test; pushes one record per cluster.
// Depends on lcbf_pkg and lcbf_ifs.
module lcbf_front
    import lcbf_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int CNT_W      = 13,
    parameter int SUM_W      = 29,
    parameter int REC_W      = 197,
    parameter int QCW        = 3,
    parameter int QDEPTH     = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    lcbf_pt_if.sink          pts,
    input  logic [29:0]      pole_radius_sq,
    input  logic [QCW-1:0]   q_used,
    output logic             push,
    output logic [REC_W-1:0] push_data
);
    logic               first_pend_reg;
    logic               s1_valid_reg, s1_first_reg;
    pt_t                s1_pt_reg;
    logic               s2_valid_reg, s2_first_reg, s2_end_reg;
    logic [31:0]        ex2_reg, ey2_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [15:0] mnx_reg, mny_reg, mnz_reg, mxx_reg, mxy_reg, mxz_reg;
    logic signed [15:0] fx_reg, fy_reg;
    logic               pole_reg;

    logic [QCW-1:0]     inflight;
    logic               accept;
    logic signed [16:0] dx, dy;
    logic [15:0]        ex, ey;
    logic [32:0]        rad_sq;
    logic               far, pole_now;

    assign inflight = QCW'(s1_valid_reg && s1_pt_reg.cluster_end)
                    + QCW'(s2_valid_reg && s2_end_reg);
    assign pts.ready = (q_used + inflight) < QCW'(QDEPTH);
    assign accept    = pts.valid && pts.ready;

    always_comb
    begin
        dx = 17'(s1_pt_reg.pt_x) - 17'(fx_reg);
        dy = 17'(s1_pt_reg.pt_y) - 17'(fy_reg);
        if (s1_first_reg)
        begin
            ex = '0;
            ey = '0;
        end
        else
        begin
            ex = dx[16] ? 16'(-dx) : dx[15:0];
            ey = dy[16] ? 16'(-dy) : dy[15:0];
        end
    end

    assign rad_sq   = 33'(ex2_reg) + 33'(ey2_reg);
    assign far      = rad_sq > 33'(pole_radius_sq);
    assign pole_now = (s2_first_reg || pole_reg) && !far;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pend_reg <= 1'b1;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            pole_reg       <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                first_pend_reg <= pts.data.cluster_end;
            end
            if (s2_valid_reg)
            begin
                pole_reg <= pole_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pt_reg    <= pts.data;
            s1_first_reg <= first_pend_reg;
        end
        ex2_reg      <= 32'(ex) * 32'(ex);
        ey2_reg      <= 32'(ey) * 32'(ey);
        s2_first_reg <= s1_first_reg;
        s2_end_reg   <= s1_pt_reg.cluster_end;
        if (s1_valid_reg)
        begin
            if (s1_first_reg)
            begin
                cnt_reg <= CNT_W'(1);
                sx_reg  <= SUM_W'(s1_pt_reg.pt_x);
                sy_reg  <= SUM_W'(s1_pt_reg.pt_y);
                sz_reg  <= SUM_W'(s1_pt_reg.pt_z);
                mnx_reg <= s1_pt_reg.pt_x;
                mny_reg <= s1_pt_reg.pt_y;
                mnz_reg <= s1_pt_reg.pt_z;
                mxx_reg <= s1_pt_reg.pt_x;
                mxy_reg <= s1_pt_reg.pt_y;
                mxz_reg <= s1_pt_reg.pt_z;
                fx_reg  <= s1_pt_reg.pt_x;
                fy_reg  <= s1_pt_reg.pt_y;
            end
            else
            begin
                if (cnt_reg < CNT_W'(MAX_POINTS))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sx_reg  <= sx_reg + SUM_W'(s1_pt_reg.pt_x);
                    sy_reg  <= sy_reg + SUM_W'(s1_pt_reg.pt_y);
                    sz_reg  <= sz_reg + SUM_W'(s1_pt_reg.pt_z);
                end
                if (s1_pt_reg.pt_x < mnx_reg) mnx_reg <= s1_pt_reg.pt_x;
                if (s1_pt_reg.pt_y < mny_reg) mny_reg <= s1_pt_reg.pt_y;
                if (s1_pt_reg.pt_z < mnz_reg) mnz_reg <= s1_pt_reg.pt_z;
                if (s1_pt_reg.pt_x > mxx_reg) mxx_reg <= s1_pt_reg.pt_x;
                if (s1_pt_reg.pt_y > mxy_reg) mxy_reg <= s1_pt_reg.pt_y;
                if (s1_pt_reg.pt_z > mxz_reg) mxz_reg <= s1_pt_reg.pt_z;
            end
        end
    end

    assign push      = s2_valid_reg && s2_end_reg;
    assign push_data = {sx_reg, sy_reg, sz_reg, cnt_reg,
                        mnx_reg, mxx_reg, mny_reg, mxy_reg, mnz_reg, mxz_reg, pole_now};
endmodule

@@ rtl/lcbf_back.sv @@
// Back end: centroid division, volume and diagonal products, verdict, output register.
// Depends on lcbf_pkg and lcbf_ifs.
module lcbf_back
    import lcbf_pkg::*;
#(
    parameter int CNT_W = 13,
    parameter int SUM_W = 29,
    parameter int REC_W = 197
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_empty,
    input  logic [REC_W-1:0] q_head,
    output logic             pop,
    lcbf_box_if.source       boxes
);
    localparam int BW = $clog2(SUM_W);
    localparam int MW = (CNT_W > 13) ? CNT_W : 13;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_VOL1, S_VOL2, S_SQX, S_SQY, S_DECIDE, S_OUT
    } state_t;

    state_t                  state_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [15:0]      mnx_reg, mxx_reg, mny_reg, mxy_reg, mnz_reg, mxz_reg;
    logic                    pole_reg;
    logic [1:0]              axis_reg;
    logic [BW-1:0]           bit_reg;
    logic [SUM_W-1:0]        num_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic                    neg_reg;
    logic signed [15:0]      cx_reg, cy_reg, cz_reg;
    logic [31:0]             t_reg;
    logic [47:0]             vol_reg;
    logic [32:0]             sq_reg;
    box_t                    out_reg;
    logic                    out_valid_reg;

    logic signed [SUM_W-1:0] head_sum;
    logic [SUM_W-1:0]        head_mag;
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        sel_mag;
    logic [CNT_W:0]          trial;
    logic                    qbit;
    logic [SUM_W-1:0]        num_next;
    logic [15:0]             quo;
    logic [15:0]             dx, dy, dz;
    logic [2:0]              verdict;
    logic signed [16:0]      hi_lim, cz_lim, lo_diff;

    always_comb
    begin
        head_sum = q_head[REC_W-1 -: SUM_W];
        head_mag = head_sum[SUM_W-1] ? SUM_W'(-head_sum) : SUM_W'(head_sum);
        // dividend of the axis that follows the current one
        case (axis_reg)
            2'd0:    sel_sum = sy_reg;
            default: sel_sum = sz_reg;
        endcase
        sel_mag  = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
        trial    = {rem_reg, num_reg[SUM_W-1]};
        qbit     = trial >= {1'b0, cnt_reg};
        num_next = {num_reg[SUM_W-2:0], qbit};
        quo      = neg_reg ? 16'(-num_next) : num_next[15:0];
    end

    assign dx = 16'(mxx_reg - mnx_reg);
    assign dy = 16'(mxy_reg - mny_reg);
    assign dz = 16'(mxz_reg - mnz_reg);
    assign hi_lim  = 17'(cfg.vehicle_height) + 17'(cfg.high_base_margin);
    assign cz_lim  = 17'(cfg.vehicle_height) + 17'(cfg.under_z_margin);
    assign lo_diff = 17'(mxz_reg) - 17'(cfg.vehicle_height);

    always_comb
    begin
        if (MW'(cnt_reg) <= MW'(cfg.pole_point_limit) && pole_reg)
            verdict = V_POLE;
        else if (vol_reg <= {cfg.max_small_volume, 16'd0})
            verdict = V_SMALL;
        else if (17'(mnz_reg) > hi_lim)
            verdict = V_HIGH;
        else if (dz <= FLAT_DZ_MAX)
            verdict = V_FLAT;
        else if (lo_diff <= LOW_MARGIN)
            verdict = V_LOW;
        else if (sq_reg > 33'(LONG_DIAG_SQ) && dz < LONG_DZ_LIM)
            verdict = V_LONG_FLAT;
        else if (17'(cz_reg) >= cz_lim)
            verdict = V_CENTRE_HI;
        else
            verdict = V_KEPT;
    end

    assign pop = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        axis_reg  <= 2'd0;
                        bit_reg   <= BW'(SUM_W-1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (bit_reg == '0)
                    begin
                        bit_reg <= BW'(SUM_W-1);
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= S_VOL1;
                        end
                        axis_reg <= axis_reg + 1'b1;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                S_VOL1:   state_reg <= S_VOL2;
                S_VOL2:   state_reg <= S_SQX;
                S_SQX:    state_reg <= S_SQY;
                S_SQY:    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (boxes.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            {sx_reg, sy_reg, sz_reg, cnt_reg,
             mnx_reg, mxx_reg, mny_reg, mxy_reg, mnz_reg, mxz_reg, pole_reg} <= q_head;
            num_reg <= head_mag;
            neg_reg <= head_sum[SUM_W-1];
            rem_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            if (bit_reg == '0)
            begin
                case (axis_reg)
                    2'd0:    cx_reg <= quo;
                    2'd1:    cy_reg <= quo;
                    default: cz_reg <= quo;
                endcase
                num_reg <= (axis_reg == 2'd2) ? '0 : sel_mag;
                neg_reg <= sel_sum[SUM_W-1];
                rem_reg <= '0;
            end
            else
            begin
                num_reg <= num_next;
                rem_reg <= qbit ? CNT_W'(trial - {1'b0, cnt_reg}) : CNT_W'(trial);
            end
        end
        if (state_reg == S_VOL1) t_reg   <= 32'(dx) * 32'(dy);
        if (state_reg == S_VOL2) vol_reg <= 48'(t_reg) * 48'(dz);
        if (state_reg == S_SQX)  sq_reg  <= 33'(32'(dx) * 32'(dx));
        if (state_reg == S_SQY)  sq_reg  <= sq_reg + 33'(32'(dy) * 32'(dy));
        if (state_reg == S_DECIDE)
        begin
            out_reg.center_x  <= cx_reg;
            out_reg.center_y  <= cy_reg;
            out_reg.center_z  <= cz_reg;
            out_reg.box_min_x <= mnx_reg;
            out_reg.box_max_x <= mxx_reg;
            out_reg.box_min_y <= mny_reg;
            out_reg.box_max_y <= mxy_reg;
            out_reg.box_min_z <= mnz_reg;
            out_reg.box_max_z <= mxz_reg;
            out_reg.verdict   <= verdict;
        end
    end

    assign boxes.valid = out_valid_reg;
    assign boxes.data  = out_reg;
endmodule

@@ rtl/lidar_cluster_box_filter_core.sv @@
// Top level of the lidar cluster box filter: configuration registers, front, queue, back.
// Depends on lcbf_pkg, lcbf_ifs, lcbf_front, lcbf_queue, lcbf_back.
//
//  port   | dir  | carries
//  pts    | in   | one point per transfer, cluster_end on the last
//  boxes  | out  | one record per cluster
//  cfg_*  | in   | register write, index 0..5
//
// Points: one per cycle while pts.ready is high; two register stages ahead of the queue.
// Per cluster the back end divides each of the three sums by shift-subtract, then
// steps S_VOL1, S_VOL2, S_SQX, S_SQY, S_DECIDE for products and verdict, then holds
// S_OUT until taken and passes S_IDLE before the next; a four-entry queue absorbs bursts.
// Reset is asynchronous; it clears all control state and loads the configuration defaults.
// pts stalls only when the queue cannot take another cluster record.
module lidar_cluster_box_filter_core
    import lcbf_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    lcbf_pt_if.sink     pts,
    lcbf_box_if.source  boxes,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = 17 + CNT_W;
    localparam int REC_W  = 3*SUM_W + CNT_W + 97;
    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);

    cfg_t             cfg_reg;
    logic [14:0]      radius_reg;
    logic             push, pop, q_empty;
    logic [REC_W-1:0] push_data, q_head;
    logic [QCW-1:0]   q_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pole_point_limit <= 13'd20;
            cfg_reg.pole_radius_sq   <= 30'd5929;
            cfg_reg.max_small_volume <= 32'd12800;
            cfg_reg.high_base_margin <= 16'sd5120;
            cfg_reg.under_z_margin   <= 16'sd128;
            cfg_reg.vehicle_height   <= 16'sd0;
            radius_reg               <= 15'd77;
        end
        else
        begin
            cfg_reg.pole_radius_sq <= 30'(radius_reg) * 30'(radius_reg);
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_POLE_POINT_LIMIT: cfg_reg.pole_point_limit <= cfg_data[12:0];
                    REG_POLE_RADIUS:      radius_reg               <= cfg_data[14:0];
                    REG_MAX_SMALL_VOLUME: cfg_reg.max_small_volume <= cfg_data;
                    REG_HIGH_BASE_MARGIN: cfg_reg.high_base_margin <= cfg_data[15:0];
                    REG_UNDER_Z_MARGIN:   cfg_reg.under_z_margin   <= cfg_data[15:0];
                    REG_VEHICLE_HEIGHT:   cfg_reg.vehicle_height   <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    lcbf_front #(
        .MAX_POINTS(MAX_POINTS), .CNT_W(CNT_W), .SUM_W(SUM_W),
        .REC_W(REC_W), .QCW(QCW), .QDEPTH(QDEPTH)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .pts(pts),
        .pole_radius_sq(cfg_reg.pole_radius_sq),
        .q_used(q_used), .push(push), .push_data(push_data)
    );

    lcbf_queue #(.W(REC_W), .DEPTH(QDEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .pop(pop), .head(q_head), .empty(q_empty), .used(q_used)
    );

    lcbf_back #(.CNT_W(CNT_W), .SUM_W(SUM_W), .REC_W(REC_W)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_empty(q_empty), .q_head(q_head), .pop(pop), .boxes(boxes)
    );
endmodule

@@ rtl/lcbf_checker.sv @@
// Port-level checks for the lidar cluster box filter, bound to the top level.
// Depends on lidar_cluster_box_filter_core.
module lcbf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] center_z,
    input logic signed [15:0] min_x,
    input logic signed [15:0] max_x,
    input logic signed [15:0] min_z,
    input logic signed [15:0] max_z
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("record dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(center_z) && $stable(max_z))
        else $error("record changed while stalled");

    a_box_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_x <= max_x)
        else $error("x box inverted");

    a_centre: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_z <= center_z && center_z <= max_z)
        else $error("centroid outside box");
endmodule

bind lidar_cluster_box_filter_core lcbf_checker u_lcbf_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(boxes.valid), .out_ready(boxes.ready),
    .center_z(boxes.data.center_z),
    .min_x(boxes.data.box_min_x), .max_x(boxes.data.box_max_x),
    .min_z(boxes.data.box_min_z), .max_z(boxes.data.box_max_z)
);
